/* hw/rtl/fdt_pkg.sv */
// Shared types, constants and helper functions of the fixed-point decimal to text block.
package fdt_pkg;

	localparam int TOTAL_DIGITS_DEF   = 19;
	localparam int INTEGER_DIGITS_DEF = 8;
	localparam int MAG_W              = 64;
	localparam int CFG_W              = 8;
	localparam int CFG_IDX_W          = 3;
	localparam int CNT_W              = 7;

	localparam logic [3:0] DEC_CAP    = 4'd10;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DECIMALS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DECIMALS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CHAR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_CHAR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_CHAR   = 3'd4;

	localparam logic [3:0] RST_MIN_DECIMALS = 4'd1;
	localparam logic [3:0] RST_MAX_DECIMALS = 4'd10;
	localparam logic [7:0] RST_MINUS_CHAR   = 8'd45;
	localparam logic [7:0] RST_GROUP_CHAR   = 8'd44;
	localparam logic [7:0] RST_POINT_CHAR   = 8'd46;

	typedef struct packed {
		logic signed [MAG_W-1:0] value;
		logic                    group_thousands;
	} item_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} char_beat_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_ROUND,
		CELL_SHIFT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       ser_bit;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_ROUND,
		ST_KEEP,
		ST_SIGN,
		ST_INT,
		ST_POINT,
		ST_FRAC
	} state_t;

	// Largest magnitude shown: nine followed by (digits - 1) zeros.
	function automatic logic [MAG_W-1:0] mag_limit(input int digits);
		logic [MAG_W-1:0] lim;
		lim = MAG_W'(9);
		for (int k = 1; k < digits; k++) begin
			lim = lim * MAG_W'(10);
		end
		return lim;
	endfunction

endpackage

/* hw/rtl/fdt_cell.sv */
// One decimal digit cell: shift-and-add-3 conversion, carry ripple and digit shifting.
module fdt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fdt_pkg::cell_ctrl_t ctrl,
	input  logic                dab_in,
	input  logic                inc_in,
	input  logic [3:0]          digit_in,
	output logic [3:0]          digit,
	output logic                dab_out,
	output logic                cy_out
);

	logic [3:0] digit_q;
	logic       cy_q;
	logic [3:0] adj;

	// Add three before the shift so the digit carries into its neighbor at ten.
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign dab_out = adj[3];
	assign digit   = digit_q;
	assign cy_out  = cy_q;

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			fdt_pkg::CELL_CLEAR:  digit_q <= 4'd0;
			fdt_pkg::CELL_DABBLE: digit_q <= {adj[2:0], dab_in};
			fdt_pkg::CELL_ROUND: begin
				if (inc_in) begin
					digit_q <= (digit_q == 4'd9) ? 4'd0 : digit_q + 4'd1;
				end
			end
			fdt_pkg::CELL_SHIFT:  digit_q <= digit_in;
			default:              digit_q <= digit_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cy_q <= 1'b0;
		end else begin
			case (ctrl.mode)
				fdt_pkg::CELL_CLEAR: cy_q <= 1'b0;
				fdt_pkg::CELL_ROUND: cy_q <= inc_in && (digit_q == 4'd9);
				default:             cy_q <= cy_q;
			endcase
		end
	end

endmodule

/* hw/rtl/fdt_chain.sv */
// Row of digit cells, least significant digit in cell zero, linked neighbor to neighbor.
module fdt_chain #(
	parameter int TOTAL_DIGITS = fdt_pkg::TOTAL_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdt_pkg::cell_ctrl_t           ctrl,
	input  logic [TOTAL_DIGITS-1:0]       inject,
	output logic [TOTAL_DIGITS-1:0][3:0]  digits
);

	logic [TOTAL_DIGITS-1:0] dab;
	logic [TOTAL_DIGITS-1:0] cy;

	for (genvar j = 0; j < TOTAL_DIGITS; j++) begin : g_cell
		logic       dab_in;
		logic       inc_in;
		logic [3:0] digit_in;

		if (j == 0) begin : g_first
			assign dab_in   = ctrl.ser_bit;
			assign inc_in   = inject[j];
			assign digit_in = 4'd0;
		end else begin : g_rest
			assign dab_in   = dab[j-1];
			assign inc_in   = cy[j-1] | inject[j];
			assign digit_in = digits[j-1];
		end

		fdt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.dab_in   (dab_in),
			.inc_in   (inc_in),
			.digit_in (digit_in),
			.digit    (digits[j]),
			.dab_out  (dab[j]),
			.cy_out   (cy[j])
		);
	end

endmodule

/* hw/rtl/fixed_decimal_to_text_top.sv */
// Top level of the fixed-point decimal to text formatter: sequencer, settings and output stage.
//
// The block takes one signed fixed-point value per input beat and sends its text one
// character per output beat, the final character flagged by last_char. The accepting cycle
// clears the digit chain and loads the magnitude with its sign removed and saturated. Then
// the magnitude is shifted into the digit chain one bit per cycle, a rounding carry ripples
// through the chain one cell per cycle, and the trimmed fraction length is worked out.
// After that come the sign slot, the integer digit positions (a leading zero is skipped,
// not printed, but the last integer digit always is), the separators between them, the
// point and the fraction digits. Each beat waits while the consumer holds char_ready low
// and the output register is full. A new value is taken as soon as the previous one has
// handed its final character to the output register. Settings are to be written through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block itself does not
// enforce this.
module fixed_decimal_to_text_top #(
	parameter int TOTAL_DIGITS   = fdt_pkg::TOTAL_DIGITS_DEF,
	parameter int INTEGER_DIGITS = fdt_pkg::INTEGER_DIGITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  fdt_pkg::item_beat_t                  item_data,
	output logic                                 char_valid,
	input  logic                                 char_ready,
	output fdt_pkg::char_beat_t                  char_data,
	input  logic                                 cfg_we,
	input  logic [fdt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fdt_pkg::CFG_W-1:0]            cfg_data
);

	localparam int FRAC_DIGITS = TOTAL_DIGITS - INTEGER_DIGITS;
	localparam int IDX_W       = $clog2(TOTAL_DIGITS);
	localparam int CNT_W       = fdt_pkg::CNT_W;
	localparam int MAG_W       = fdt_pkg::MAG_W;

	localparam logic [MAG_W-1:0] MAG_LIM    = fdt_pkg::mag_limit(TOTAL_DIGITS);
	localparam logic [CNT_W-1:0] CONV_LAST  = CNT_W'(MAG_W - 1);
	localparam logic [CNT_W-1:0] ROUND_LAST = CNT_W'(TOTAL_DIGITS - 1);
	localparam logic [CNT_W-1:0] INT_LAST   = CNT_W'(INTEGER_DIGITS - 1);
	localparam logic [1:0]       G3_INIT    = 2'(INTEGER_DIGITS % 3);

	// Settings registers.
	logic [3:0] min_dec_q;
	logic [3:0] max_dec_q;
	logic [7:0] minus_char_q;
	logic [7:0] group_char_q;
	logic [7:0] point_char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dec_q    <= fdt_pkg::RST_MIN_DECIMALS;
			max_dec_q    <= fdt_pkg::RST_MAX_DECIMALS;
			minus_char_q <= fdt_pkg::RST_MINUS_CHAR;
			group_char_q <= fdt_pkg::RST_GROUP_CHAR;
			point_char_q <= fdt_pkg::RST_POINT_CHAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdt_pkg::CFG_MIN_DECIMALS: min_dec_q    <= cfg_data[3:0];
				fdt_pkg::CFG_MAX_DECIMALS: max_dec_q    <= cfg_data[3:0];
				fdt_pkg::CFG_MINUS_CHAR:   minus_char_q <= cfg_data;
				fdt_pkg::CFG_GROUP_CHAR:   group_char_q <= cfg_data;
				fdt_pkg::CFG_POINT_CHAR:   point_char_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective fraction counts: both capped at ten, the minimum never above the maximum.
	logic [3:0] mx;
	logic [3:0] mn_cap;
	logic [3:0] mn;

	assign mx     = (max_dec_q > fdt_pkg::DEC_CAP) ? fdt_pkg::DEC_CAP : max_dec_q;
	assign mn_cap = (min_dec_q > fdt_pkg::DEC_CAP) ? fdt_pkg::DEC_CAP : min_dec_q;
	assign mn     = (mn_cap > mx) ? mx : mn_cap;

	// Sequencer registers.
	fdt_pkg::state_t  state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] sh_q;
	logic             neg_q;
	logic             grp_q;
	logic             started_q;
	logic             sepd_q;
	logic [1:0]       g3_q;
	logic [3:0]       keep_q;

	logic                char_valid_q;
	fdt_pkg::char_beat_t char_q;

	logic item_acc;
	logic emit_ok;

	assign item_ready = (state_q == fdt_pkg::ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign emit_ok    = !char_valid_q || char_ready;
	assign char_valid = char_valid_q;
	assign char_data  = char_q;

	// Magnitude with sign removed, saturated at MAG_LIM (nine followed by TOTAL_DIGITS - 1 zeros).
	logic [MAG_W-1:0] mag_abs;
	logic [MAG_W-1:0] mag_sat;

	assign mag_abs = item_data.value[MAG_W-1] ? MAG_W'(-item_data.value) : item_data.value;
	assign mag_sat = (mag_abs > MAG_LIM) ? MAG_LIM : mag_abs;

	// Digit chain.
	fdt_pkg::cell_ctrl_t          ctrl;
	logic [TOTAL_DIGITS-1:0]      inject;
	logic [TOTAL_DIGITS-1:0][3:0] digits;
	logic [3:0]                   top_digit;

	fdt_chain #(
		.TOTAL_DIGITS (TOTAL_DIGITS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.inject (inject),
		.digits (digits)
	);

	assign top_digit = digits[TOTAL_DIGITS-1];

	// Rounding looks at the first fraction digit that is dropped, if it is stored at all.
	logic             rnd_en;
	logic [IDX_W-1:0] rnd_idx;
	logic [3:0]       rnd_digit;
	logic             rnd_fire;

	assign rnd_en    = int'(mx) < FRAC_DIGITS;
	assign rnd_idx   = IDX_W'(FRAC_DIGITS - 1 - int'(mx));
	assign rnd_digit = rnd_en ? digits[rnd_idx] : 4'd0;
	assign rnd_fire  = rnd_en && (rnd_digit >= 4'd5);

	// Zero flags of the fraction digits; digits past the stored ones read as zero.
	logic [fdt_pkg::DEC_CAP-1:0] fz;

	for (genvar k = 0; k < fdt_pkg::DEC_CAP; k++) begin : g_fz
		if (k < FRAC_DIGITS) begin : g_stored
			assign fz[k] = (digits[FRAC_DIGITS-1-k] == 4'd0);
		end else begin : g_beyond
			assign fz[k] = 1'b1;
		end
	end

	// Trimmed length: last nonzero digit, at least the minimum and one; zero if max is zero.
	logic [3:0] lnz;
	logic [3:0] keep_n;

	always_comb begin
		lnz = 4'd0;
		for (int k = 0; k < fdt_pkg::DEC_CAP; k++) begin
			if ((4'(k) < mx) && !fz[k]) begin
				lnz = 4'(k + 1);
			end
		end
		if (mx == 4'd0) begin
			keep_n = 4'd0;
		end else begin
			keep_n = lnz;
			if (keep_n < mn) begin
				keep_n = mn;
			end
			if (keep_n == 4'd0) begin
				keep_n = 4'd1;
			end
		end
	end

	// Sequencer outputs.
	logic                emit;
	fdt_pkg::char_beat_t beat;
	logic                int_step;
	logic                sep_emit;
	logic                cnt_inc;
	logic                int_last;
	logic                frac_last;

	assign int_last  = (cnt_q == INT_LAST);
	assign frac_last = (cnt_q == CNT_W'(keep_q) - CNT_W'(1));

	always_comb begin
		ctrl.mode      = fdt_pkg::CELL_HOLD;
		ctrl.ser_bit   = sh_q[MAG_W-1];
		inject         = '0;
		emit           = 1'b0;
		beat.out_char  = 8'd0;
		beat.last_char = 1'b0;
		int_step       = 1'b0;
		sep_emit       = 1'b0;
		cnt_inc        = 1'b0;
		unique case (state_q)
			fdt_pkg::ST_IDLE: begin
				if (item_acc) begin
					ctrl.mode = fdt_pkg::CELL_CLEAR;
				end
			end
			fdt_pkg::ST_CONV: begin
				ctrl.mode = fdt_pkg::CELL_DABBLE;
				cnt_inc   = 1'b1;
			end
			fdt_pkg::ST_ROUND: begin
				ctrl.mode = fdt_pkg::CELL_ROUND;
				cnt_inc   = 1'b1;
				if ((cnt_q == '0) && rnd_fire) begin
					inject = TOTAL_DIGITS'(1) << (rnd_idx + IDX_W'(1));
				end
			end
			fdt_pkg::ST_KEEP: ;
			fdt_pkg::ST_SIGN: begin
				if (neg_q && emit_ok) begin
					emit          = 1'b1;
					beat.out_char = minus_char_q;
				end
			end
			fdt_pkg::ST_INT: begin
				if (!started_q && (top_digit == 4'd0) && !int_last) begin
					// Leading zero: drop it without a beat.
					ctrl.mode = fdt_pkg::CELL_SHIFT;
					int_step  = 1'b1;
					cnt_inc   = 1'b1;
				end else if (started_q && grp_q && (g3_q == 2'd0) && !sepd_q) begin
					if (emit_ok) begin
						emit          = 1'b1;
						sep_emit      = 1'b1;
						beat.out_char = group_char_q;
					end
				end else if (emit_ok) begin
					emit           = 1'b1;
					beat.out_char  = fdt_pkg::ASCII_ZERO + {4'd0, top_digit};
					beat.last_char = int_last && (mx == 4'd0);
					ctrl.mode      = fdt_pkg::CELL_SHIFT;
					int_step       = 1'b1;
					cnt_inc        = 1'b1;
				end
			end
			fdt_pkg::ST_POINT: begin
				if (emit_ok) begin
					emit          = 1'b1;
					beat.out_char = point_char_q;
				end
			end
			fdt_pkg::ST_FRAC: begin
				if (emit_ok) begin
					emit           = 1'b1;
					beat.out_char  = fdt_pkg::ASCII_ZERO + {4'd0, top_digit};
					beat.last_char = frac_last;
					ctrl.mode      = fdt_pkg::CELL_SHIFT;
					cnt_inc        = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			fdt_pkg::ST_IDLE: begin
				if (item_acc) begin
					state_n = fdt_pkg::ST_CONV;
				end
			end
			fdt_pkg::ST_CONV: begin
				if (cnt_q == CONV_LAST) begin
					state_n = fdt_pkg::ST_ROUND;
				end
			end
			fdt_pkg::ST_ROUND: begin
				if (cnt_q == ROUND_LAST) begin
					state_n = fdt_pkg::ST_KEEP;
				end
			end
			fdt_pkg::ST_KEEP: state_n = fdt_pkg::ST_SIGN;
			fdt_pkg::ST_SIGN: begin
				if (!neg_q || emit_ok) begin
					state_n = fdt_pkg::ST_INT;
				end
			end
			fdt_pkg::ST_INT: begin
				if (int_step && int_last) begin
					state_n = (mx == 4'd0) ? fdt_pkg::ST_IDLE : fdt_pkg::ST_POINT;
				end
			end
			fdt_pkg::ST_POINT: begin
				if (emit_ok) begin
					state_n = fdt_pkg::ST_FRAC;
				end
			end
			fdt_pkg::ST_FRAC: begin
				if (emit_ok && frac_last) begin
					state_n = fdt_pkg::ST_IDLE;
				end
			end
			default: state_n = fdt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer state and per-value bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fdt_pkg::ST_IDLE;
			cnt_q     <= '0;
			neg_q     <= 1'b0;
			grp_q     <= 1'b0;
			started_q <= 1'b0;
			sepd_q    <= 1'b0;
			g3_q      <= 2'd0;
			keep_q    <= 4'd0;
		end else begin
			state_q <= state_n;
			if (state_n != state_q) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (item_acc) begin
				neg_q <= item_data.value[MAG_W-1];
				grp_q <= item_data.group_thousands;
			end
			if (state_q == fdt_pkg::ST_KEEP) begin
				keep_q    <= keep_n;
				started_q <= 1'b0;
				sepd_q    <= 1'b0;
				g3_q      <= G3_INIT;
			end
			if (sep_emit) begin
				sepd_q <= 1'b1;
			end
			if (int_step) begin
				sepd_q <= 1'b0;
				g3_q   <= (g3_q == 2'd0) ? 2'd2 : g3_q - 2'd1;
				if (emit) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	// Magnitude shift register feeding the chain, most significant bit first.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			sh_q <= mag_sat;
		end else if (state_q == fdt_pkg::ST_CONV) begin
			sh_q <= {sh_q[MAG_W-2:0], 1'b0};
		end
	end

	// Output register: holds a beat for the consumer; a new beat is only loaded once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (emit) begin
			char_valid_q <= 1'b1;
		end else if (char_ready) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= beat;
		end
	end

	// Every cell holds a decimal digit once conversion and rounding are over.
	logic bcd_ok;

	always_comb begin
		bcd_ok = 1'b1;
		for (int j = 0; j < TOTAL_DIGITS; j++) begin
			if (digits[j] > 4'd9) begin
				bcd_ok = 1'b0;
			end
		end
	end

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdt_pkg::ST_KEEP) |-> bcd_ok)
		else $error("digit chain holds a non-decimal digit after conversion");

	a_single_inject: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(inject) && ((inject == '0) || (state_q == fdt_pkg::ST_ROUND && cnt_q == '0)))
		else $error("rounding carry injected outside the first rounding cycle");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdt_pkg::ST_FRAC) |-> (keep_q != 4'd0) && (cnt_q < CNT_W'(keep_q)))
		else $error("fraction digit count ran past the trimmed length");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!char_valid_q || char_ready))
		else $error("beat produced while the output register is still occupied");

endmodule
